/* hw/rtl/haptic_spring_force_loop_defines.svh */
// ----------------------------------------------------------------------------
// haptic spring force loop assertion macros
// concurrent checks that drop away in synthesis
// ----------------------------------------------------------------------------
`ifndef HAPTIC_SPRING_FORCE_LOOP_DEFINES_SVH
`define HAPTIC_SPRING_FORCE_LOOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define HSFL_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed: cond then cons");

// next-cycle implication, checked out of reset
`define HSFL_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed: cond then next cons");

`else

`define HSFL_ASSERT_SAME(label, clk, rst_n, cond, cons)
`define HSFL_ASSERT_NEXT(label, clk, rst_n, cond, cons)

`endif

`endif

/* hw/rtl/hsfl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haptic spring force loop package
// field widths, register indexes, reset values and loop constants
// ----------------------------------------------------------------------------
package hsfl_pkg;

    localparam int unsigned ANGLE_W   = 10;
    localparam int unsigned CURRENT_W = 10;
    localparam int unsigned DUTY_W    = 16;
    localparam int unsigned FORCE_W   = 16;
    localparam int unsigned STEP_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned S_DATA_W  = 24;
    localparam int unsigned M_DATA_W  = 40;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_POSITION  = 2'd2;

    // register reset values
    localparam logic [ANGLE_W-1:0] FLIP_THRESHOLD_RST = 10'd600;
    localparam logic [STEP_W-1:0]  INTEGRAL_STEP_RST  = 16'd100;
    localparam logic [ANGLE_W-1:0] ZERO_POSITION_RST  = 10'd0;

    // position and spring law
    localparam logic [FORCE_W-1:0] WRAP_SPAN    = 16'd700;
    localparam logic [FORCE_W-1:0] FORCE_CENTER = 16'd800;
    localparam int unsigned        FORCE_SHIFT  = 6;

    // duty limits and dead bands
    localparam logic signed [17:0] ERR_BAND      = 18'sd2;
    localparam logic signed [17:0] DUTY_MAX      = 18'sd65000;
    localparam logic [DUTY_W-1:0]  BAND_LO_LOW   = 16'd3500;
    localparam logic [DUTY_W-1:0]  BAND_LO_HIGH  = 16'd5500;
    localparam logic [DUTY_W-1:0]  BAND_LO_JUMP  = 16'd8000;
    localparam logic [DUTY_W-1:0]  BAND_HI_LOW   = 16'd5549;
    localparam logic [DUTY_W-1:0]  BAND_HI_HIGH  = 16'd7900;
    localparam logic [DUTY_W-1:0]  BAND_HI_JUMP  = 16'd3400;

endpackage

/* hw/rtl/haptic_spring_force_loop.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haptic spring force loop
// angle unwrap, spring force law and integral duty control, one tick per item
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one item per control tick, angle and current samples
//   m_ channel: one item per input item, pwm_update flag in tuser,
//     direction, duty and desired force in tdata
//   cfg channel: register writes, only while no item is in flight, a rule
//     for the user that the block does not enforce; writing zero_position
//     also reloads the angle history
// datapath and throughput
//   an accepted item waits in the input register, is worked in one pass of
//   combinational logic and lands in the result register, one item per cycle
//   while m_tready is high; wrap and duty feedback close within that pass
// reset
//   registers return to 600 / 100 / 0, history to zero_position, wrap and
//   duty state to zero, both channels empty
// stalls
//   a held result keeps the input register full; s_tready drops only when
//   both the input and the result register are occupied
// ----------------------------------------------------------------------------
`include "haptic_spring_force_loop_defines.svh"

module haptic_spring_force_loop
    import hsfl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_data,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // angle_sample [9:0], current_sample [19:10], zero fill [23:20]
    input  logic [S_DATA_W-1:0]   s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // drive_forward [0], duty [16:1], desired_force [32:17], zero fill [39:33]
    output logic [M_DATA_W-1:0]   m_tdata,
    // pwm_update [0]
    output logic                  m_tuser
);

    logic [ANGLE_W-1:0]   flip_threshold_reg;
    logic [STEP_W-1:0]    integral_step_reg;
    logic [ANGLE_W-1:0]   zero_position_reg;

    logic [ANGLE_W-1:0]   previous_angle_reg;
    logic [ANGLE_W-1:0]   older_angle_reg;
    logic [FORCE_W-1:0]   wrap_offset_reg;
    logic [FORCE_W-1:0]   wrap_offset_next;
    logic                 wrap_seen_reg;
    logic                 wrap_seen_next;
    logic [DUTY_W-1:0]    duty_acc_reg;
    logic [DUTY_W-1:0]    duty_acc_next;

    logic                 in_valid_reg;
    logic [ANGLE_W-1:0]   in_angle_reg;
    logic [CURRENT_W-1:0] in_current_reg;

    logic                 out_valid_reg;
    logic                 out_update_reg;
    logic                 out_forward_reg;
    logic [DUTY_W-1:0]    out_duty_reg;
    logic [FORCE_W-1:0]   out_force_reg;

    logic                 advance;
    logic                 fire;

    logic signed [10:0]   jump;
    logic [10:0]          jump_mag;
    logic                 wrap_hit;
    logic [FORCE_W-1:0]   neg_offset;
    logic [FORCE_W-1:0]   shifted;
    logic [FORCE_W-1:0]   force_bits;
    logic [16:0]          force_mag;
    logic signed [17:0]   err;
    logic                 update_next;
    logic signed [17:0]   duty_sum;
    logic [DUTY_W-1:0]    duty_clamped;
    logic [DUTY_W-1:0]    duty_banded;
    logic                 forward_next;
    logic                 duty_legal;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_update_reg;
    assign m_tdata  = {7'd0, out_force_reg, out_duty_reg, out_forward_reg};

    always_comb begin
        jump     = $signed({1'b0, in_angle_reg}) - $signed({1'b0, older_angle_reg});
        jump_mag = jump[10] ? 11'(-jump) : 11'(jump);
        wrap_hit = (jump_mag > {1'b0, flip_threshold_reg}) && !wrap_seen_reg;
        wrap_seen_next = wrap_hit;

        wrap_offset_next = wrap_offset_reg;
        if (wrap_hit) begin
            if (jump[10]) begin
                wrap_offset_next = wrap_offset_reg + WRAP_SPAN;
            end else begin
                wrap_offset_next = wrap_offset_reg - WRAP_SPAN;
            end
        end

        // negated offset from centre: centre - (angle + wraps - zero)
        neg_offset = FORCE_CENTER + {6'd0, zero_position_reg}
                   - {6'd0, in_angle_reg} - wrap_offset_next;
        shifted    = 16'($signed(neg_offset) >>> FORCE_SHIFT);
        force_bits = (shifted << 2) + shifted;
        forward_next = !force_bits[15] && (force_bits != '0);

        force_mag = force_bits[15] ? (17'd0 - {1'b1, force_bits}) : {1'b0, force_bits};
        err = $signed({1'b0, force_mag}) - $signed({8'd0, in_current_reg});
        update_next = (err > ERR_BAND) || (err < -ERR_BAND);

        if (err < 0) begin
            duty_sum = $signed({2'b00, duty_acc_reg}) - $signed({2'b00, integral_step_reg});
        end else begin
            duty_sum = $signed({2'b00, duty_acc_reg}) + $signed({2'b00, integral_step_reg});
        end

        if (duty_sum < 0) begin
            duty_clamped = '0;
        end else if (duty_sum > DUTY_MAX) begin
            duty_clamped = DUTY_MAX[DUTY_W-1:0];
        end else begin
            duty_clamped = duty_sum[DUTY_W-1:0];
        end

        duty_banded = duty_clamped;
        if (duty_banded > BAND_LO_LOW && duty_banded < BAND_LO_HIGH) begin
            duty_banded = BAND_LO_JUMP;
        end
        if (duty_banded > BAND_HI_LOW && duty_banded < BAND_HI_HIGH) begin
            duty_banded = BAND_HI_JUMP;
        end

        duty_acc_next = update_next ? duty_banded : duty_acc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flip_threshold_reg <= FLIP_THRESHOLD_RST;
            integral_step_reg  <= INTEGRAL_STEP_RST;
            zero_position_reg  <= ZERO_POSITION_RST;
            previous_angle_reg <= ZERO_POSITION_RST;
            older_angle_reg    <= ZERO_POSITION_RST;
            wrap_offset_reg    <= '0;
            wrap_seen_reg      <= 1'b0;
            duty_acc_reg       <= '0;
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end

            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (fire) begin
                older_angle_reg    <= previous_angle_reg;
                previous_angle_reg <= in_angle_reg;
                wrap_offset_reg    <= wrap_offset_next;
                wrap_seen_reg      <= wrap_seen_next;
                duty_acc_reg       <= duty_acc_next;
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FLIP_THRESHOLD: begin
                        flip_threshold_reg <= cfg_data[ANGLE_W-1:0];
                    end
                    CFG_INTEGRAL_STEP: begin
                        integral_step_reg <= cfg_data;
                    end
                    CFG_ZERO_POSITION: begin
                        zero_position_reg  <= cfg_data[ANGLE_W-1:0];
                        previous_angle_reg <= cfg_data[ANGLE_W-1:0];
                        older_angle_reg    <= cfg_data[ANGLE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_angle_reg   <= s_tdata[ANGLE_W-1:0];
            in_current_reg <= s_tdata[ANGLE_W+CURRENT_W-1:ANGLE_W];
        end
        if (fire) begin
            out_update_reg  <= update_next;
            out_forward_reg <= forward_next;
            out_duty_reg    <= duty_acc_next;
            out_force_reg   <= force_bits;
        end
    end

    // duty within limits and outside both dead bands
    assign duty_legal = (duty_acc_reg <= DUTY_MAX[DUTY_W-1:0])
                      && !(duty_acc_reg > BAND_LO_LOW && duty_acc_reg < BAND_LO_HIGH)
                      && !(duty_acc_reg > BAND_HI_LOW && duty_acc_reg < BAND_HI_HIGH);

    `HSFL_ASSERT_SAME(a_duty_outside_bands, aclk, aresetn, 1'b1, duty_legal)
    `HSFL_ASSERT_SAME(a_ready_when_out_empty, aclk, aresetn, !m_tvalid, s_tready)
    `HSFL_ASSERT_NEXT(a_duty_held_no_update, aclk, aresetn, fire && !update_next, $stable(duty_acc_reg))

endmodule

/* tb/sv/haptic_spring_force_loop_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haptic spring force loop testbench
// drives angle and current items through the block and keeps its own copy of
// the unwrap, spring force and integral duty state; every result item is
// compared field by field with the oldest predicted one, under random gaps on
// the input side, random back-pressure on the result side and a sequence of
// register settings that takes in the extremes
// ----------------------------------------------------------------------------
module haptic_spring_force_loop_test;
    import hsfl_pkg::*;

    localparam int unsigned CLK_PERIOD   = 20;
    localparam int unsigned RESET_CYCLES = 10;
    localparam int unsigned IDLE_LIMIT   = 3000;
    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam int unsigned PHASE_ITEMS  = 100;
    localparam int unsigned CALM_TAIL    = 200;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam logic [FORCE_W-1:0]   FORCE_GAIN      = 16'd5;

    typedef struct packed {
        logic                pwm_update;
        logic                drive_forward;
        logic [DUTY_W-1:0]   duty;
        logic [FORCE_W-1:0]  desired_force;
    } loop_result_t;

    class force_loop_scoreboard;
        logic [ANGLE_W-1:0] flip_threshold;
        logic [STEP_W-1:0]  integral_step;
        logic [ANGLE_W-1:0] zero_position;
        logic [ANGLE_W-1:0] previous_angle;
        logic [ANGLE_W-1:0] older_angle;
        logic [15:0]        wrap_count;
        bit                 wrap_seen_last;
        logic [DUTY_W-1:0]  duty_level;
        loop_result_t       expected_results[$];
        int unsigned        failures;

        function new();
            flip_threshold = FLIP_THRESHOLD_RST;
            integral_step  = INTEGRAL_STEP_RST;
            zero_position  = ZERO_POSITION_RST;
            previous_angle = ZERO_POSITION_RST;
            older_angle    = ZERO_POSITION_RST;
            wrap_count     = '0;
            wrap_seen_last = 1'b0;
            duty_level     = '0;
            failures       = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] value);
            case (index)
                CFG_FLIP_THRESHOLD: flip_threshold = value[ANGLE_W-1:0];
                CFG_INTEGRAL_STEP:  integral_step  = value[STEP_W-1:0];
                CFG_ZERO_POSITION: begin
                    zero_position  = value[ANGLE_W-1:0];
                    previous_angle = value[ANGLE_W-1:0];
                    older_angle    = value[ANGLE_W-1:0];
                end
                default: ;
            endcase
        endfunction

        function void note_sample(logic [ANGLE_W-1:0] angle, logic [CURRENT_W-1:0] current);
            int                 jump;
            int                 jump_mag;
            logic [15:0]        position;
            logic [15:0]        offset;
            logic signed [15:0] pull;
            logic signed [15:0] shifted;
            logic [15:0]        force_bits;
            logic signed [15:0] force_signed;
            int                 force_val;
            int                 force_mag;
            int                 err;
            int                 d;
            loop_result_t       r;
            jump = int'(angle) - int'(older_angle);
            jump_mag = (jump < 0) ? -jump : jump;
            older_angle = previous_angle;
            previous_angle = angle;
            // a wrap directly after a counted one is ignored
            if (jump_mag > int'(flip_threshold) && !wrap_seen_last) begin
                if (jump > 0)
                    wrap_count = wrap_count - 16'd1;
                else
                    wrap_count = wrap_count + 16'd1;
                wrap_seen_last = 1'b1;
            end else begin
                wrap_seen_last = 1'b0;
            end
            position = {6'd0, angle} + wrap_count * WRAP_SPAN - {6'd0, zero_position};
            offset = position - FORCE_CENTER;
            pull = 16'd0 - offset;
            shifted = pull >>> FORCE_SHIFT;
            force_bits = shifted * FORCE_GAIN;
            force_signed = force_bits;
            force_val = int'(force_signed);
            force_mag = (force_val < 0) ? -force_val : force_val;
            err = force_mag - int'(current);
            r.pwm_update = 1'b0;
            if (err > int'(ERR_BAND) || err < -int'(ERR_BAND)) begin
                d = int'(duty_level);
                if (err < 0)
                    d -= int'(integral_step);
                else
                    d += int'(integral_step);
                if (d < 0)
                    d = 0;
                if (d > int'(DUTY_MAX))
                    d = int'(DUTY_MAX);
                // dead bands, lower one first
                if (d > int'(BAND_LO_LOW) && d < int'(BAND_LO_HIGH))
                    d = int'(BAND_LO_JUMP);
                if (d > int'(BAND_HI_LOW) && d < int'(BAND_HI_HIGH))
                    d = int'(BAND_HI_JUMP);
                duty_level = d[DUTY_W-1:0];
                r.pwm_update = 1'b1;
            end
            r.drive_forward = (force_val > 0);
            r.duty = duty_level;
            r.desired_force = force_bits;
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
            if (act_val !== exp_val) begin
                $display("%0t: %s mismatch expected %0d actual %0d", $time, name,
                         exp_val, act_val);
                failures++;
            end
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data, logic user);
            loop_result_t e;
            if (expected_results.size() == 0) begin
                $display("%0t: result item with none expected, expected nothing actual %h / %b",
                         $time, data, user);
                failures++;
                return;
            end
            e = expected_results.pop_front();
            compare_field("pwm_update", {15'd0, e.pwm_update}, {15'd0, user});
            compare_field("drive_forward", {15'd0, e.drive_forward}, {15'd0, data[0]});
            compare_field("duty", e.duty, data[DUTY_W:1]);
            compare_field("desired_force", e.desired_force, data[DUTY_W+FORCE_W:DUTY_W+1]);
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DAT_W-1:0]  cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;

    force_loop_scoreboard  loop_model;
    bit                    calm;
    logic [ANGLE_W-1:0]    angle_track;
    int unsigned           idle_cycles = 0;

    haptic_spring_force_loop DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                loop_model.write_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                loop_model.note_sample(s_tdata[ANGLE_W-1:0],
                                       s_tdata[ANGLE_W+CURRENT_W-1:ANGLE_W]);
            if (m_tvalid && m_tready)
                loop_model.check_result(m_tdata, m_tuser);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("%0t: no item accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // result side back-pressure
    initial begin
        int unsigned hold;
        hold = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold == 0 && !calm && $urandom_range(0, 4) == 0)
                hold = $urandom_range(1, 7);
            if (hold != 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task send_sample(input logic [ANGLE_W-1:0] angle, input logic [CURRENT_W-1:0] current);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_DATA_W-ANGLE_W-CURRENT_W){1'b0}}, current, angle};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    task stop_samples();
        s_tvalid <= 1'b0;
    endtask

    task put_register(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DAT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
    endtask

    task close_registers();
        cfg_valid <= 1'b0;
    endtask

    task wait_drained();
        @(posedge aclk);
        while (loop_model.pending() != 0) @(posedge aclk);
    endtask

    task randomise_settings();
        logic [ANGLE_W-1:0] threshold;
        logic [STEP_W-1:0]  step;
        wait_drained();
        case ($urandom_range(0, 3))
            0: threshold = '0;
            1: threshold = '1;
            2: threshold = 10'($urandom_range(400, 700));
            default: threshold = 10'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0: step = '0;
            1: step = '1;
            2: step = 16'($urandom_range(1, 300));
            default: step = 16'($urandom);
        endcase
        if ($urandom_range(0, 1) == 0)
            put_register(CFG_FLIP_THRESHOLD, {6'($urandom), threshold});
        if ($urandom_range(0, 5) == 0)
            put_register(CFG_SPARE_INDEX, 16'($urandom));
        if ($urandom_range(0, 1) == 0)
            put_register(CFG_ZERO_POSITION, 16'($urandom));
        put_register(CFG_INTEGRAL_STEP, step);
        close_registers();
    endtask

    // mostly smooth rotation with occasional glitches, otherwise raw noise
    task run_random_phase(input int unsigned count);
        bit                  smooth;
        int unsigned         span;
        logic [ANGLE_W-1:0]  angle;
        logic [CURRENT_W-1:0] current;
        smooth = $urandom_range(0, 9) < 7;
        span = ($urandom_range(0, 1) == 0) ? 24 : 300;
        for (int unsigned i = 0; i < count; i++) begin
            if (smooth && $urandom_range(0, 19) != 0) begin
                angle_track = angle_track + 10'($urandom_range(0, 2 * span)) - 10'(span);
                angle = angle_track;
            end else begin
                angle = 10'($urandom);
            end
            if ($urandom_range(0, 1) == 0)
                current = 10'($urandom_range(0, 80));
            else
                current = 10'($urandom);
            send_sample(angle, current);
        end
        stop_samples();
    endtask

    initial begin
        int unsigned sent;
        sent = 0;
        calm = 1'b0;
        angle_track = '0;
        loop_model = new();
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_FLIP_THRESHOLD;
        cfg_data <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: error band edges, wraps both ways, ignored second wrap
        send_sample(10'd0, 10'd60);
        send_sample(10'd0, 10'd62);
        send_sample(10'd0, 10'd57);
        send_sample(10'd0, 10'd63);
        send_sample(10'd1023, 10'd1023);
        send_sample(10'd1023, 10'd0);
        send_sample(10'd0, 10'd1023);
        send_sample(10'd0, 10'd0);
        send_sample(10'd512, 10'd512);
        send_sample(10'd1023, 10'd0);
        stop_samples();

        // full step, zero threshold: saturation at both ends
        wait_drained();
        put_register(CFG_SPARE_INDEX, 16'hFFFF);
        put_register(CFG_FLIP_THRESHOLD, 16'h0000);
        put_register(CFG_INTEGRAL_STEP, 16'hFFFF);
        put_register(CFG_ZERO_POSITION, 16'hFFFF);
        close_registers();
        send_sample(10'd1023, 10'd0);
        send_sample(10'd1023, 10'd0);
        send_sample(10'd1022, 10'd1023);
        send_sample(10'd0, 10'd1023);
        send_sample(10'd1, 10'd1023);
        send_sample(10'd2, 10'd0);
        stop_samples();

        // walk the duty through both dead bands
        wait_drained();
        put_register(CFG_FLIP_THRESHOLD, 16'h03FF);
        put_register(CFG_INTEGRAL_STEP, 16'd1000);
        put_register(CFG_ZERO_POSITION, 16'h0000);
        close_registers();
        repeat (6) send_sample(10'd0, 10'd0);
        repeat (4) send_sample(10'd0, 10'd1023);
        stop_samples();

        while (sent < RANDOM_ITEMS) begin
            randomise_settings();
            calm = (sent + CALM_TAIL >= RANDOM_ITEMS) || ($urandom_range(0, 3) == 0);
            run_random_phase(PHASE_ITEMS);
            sent += PHASE_ITEMS;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (loop_model.failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
